// ----- rtl/core/mi_pkg.sv -----
// ----------------------------------------------------------------------------
// mi_pkg: shared types and constants for the modular inverse block
// Field widths, status codes and the control/status bundles of the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package mi_pkg;

  localparam int VALUE_W   = 16;
  localparam int MOD_IN_W  = 32;
  localparam int INVERSE_W = 32;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/mi_in_if.sv -----
// ----------------------------------------------------------------------------
// mi_in_if: input channel of the modular inverse block
// Valid/ready handshake carrying a value and a modulus per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mi_in_if;
  logic                          valid;
  logic                          ready;
  logic [mi_pkg::VALUE_W-1:0]    value;
  logic [mi_pkg::MOD_IN_W-1:0]   modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mi_out_if.sv -----
// ----------------------------------------------------------------------------
// mi_out_if: result channel of the modular inverse block
// Valid/ready handshake carrying an inverse and a status per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mi_out_if;
  logic                          valid;
  logic                          ready;
  logic [mi_pkg::INVERSE_W-1:0]  inverse;
  logic                          status;

  modport source (output valid, output inverse, output status, input ready);
  modport sink   (input valid, input inverse, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mi_div_unit.sv -----
// ----------------------------------------------------------------------------
// mi_div_unit: iterative restoring divider with coefficient accumulation
// One quotient bit per cycle, MSB first. Alongside the remainder it forms
// q * coef by shift-and-add, so one Euclid round needs one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mi_div_unit #(
  parameter int W  = 32,
  parameter int DW = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire mi_pkg::div_ctl_t ctl,
  input  wire  [DW-1:0]         dividend,
  input  wire  [W-1:0]          divisor,
  input  wire  [W-1:0]          coef,
  output mi_pkg::div_sts_t      sts,
  output logic [W-1:0]          rem,
  output logic [W-1:0]          acc
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    dvd_r, dvd_nxt;
  logic [W-1:0]     dsr_r, dsr_nxt;
  logic [W-1:0]     coef_r, coef_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     acc_r, acc_nxt;

  logic [W:0]       rem_sh;
  logic [W:0]       diff;
  logic             qbit;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[DW-1]};
    diff     = rem_sh - {1'b0, dsr_r};
    qbit     = ~diff[W];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    coef_nxt = coef_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DW);
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      coef_nxt = coef;
      rem_nxt  = '0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DW-2:0], 1'b0};
      rem_nxt = qbit ? diff[W-1:0] : rem_sh[W-1:0];
      acc_nxt = {acc_r[W-2:0], 1'b0} + (qbit ? coef_r : '0);
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
    coef_r <= coef_nxt;
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign rem      = rem_r;
  assign acc      = acc_r;

endmodule

`default_nettype wire

// ----- rtl/core/modular_inverse.sv -----
// ----------------------------------------------------------------------------
// modular_inverse: extended Euclidean modular inverse
// Accepts a value and a modulus on in_bus and returns value^-1 mod modulus
// with a status bit on out_bus.
//
// Usage:
//   in_bus : one beat per item (value, modulus); the low MODULUS_BITS bits of
//            modulus are used. in_bus.ready is high only while the block idles.
//   out_bus: one beat per item (inverse, status). status 1 means no inverse
//            (modulus below two, value zero mod modulus or gcd not one), and
//            then inverse is zero.
//   Divider: each Euclid round is one pass of the bit-serial divider over
//            DW = max(MODULUS_BITS, 16) quotient bits, one quotient bit per
//            cycle; the first pass reduces the value modulo the modulus.
//   Throughput: one item at a time; the next beat is taken once the result
//            sits in the output register.
//   Stall: a result held by a low out_bus.ready stays in the output register;
//            a later result waits in its final state until the register frees.
//   Reset: rst_n (synchronous, active low) drops any item at work and any
//            pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse #(
  parameter int MODULUS_BITS = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  mi_in_if.sink      in_bus,
  mi_out_if.source   out_bus
);

  localparam int W  = MODULUS_BITS;
  localparam int DW = (MODULUS_BITS > mi_pkg::VALUE_W) ? MODULUS_BITS : mi_pkg::VALUE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CHECK,
    S_DIV,
    S_FIN_RED,
    S_FIN_NEG,
    S_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  logic [W-1:0]                   m_r, m_nxt;
  logic [W-1:0]                   r0_r, r0_nxt;
  logic [W-1:0]                   r1_r, r1_nxt;
  logic [W-1:0]                   t0_r, t0_nxt;
  logic [W-1:0]                   t1_r, t1_nxt;
  logic                           neg_r, neg_nxt;
  logic [W-1:0]                   res_inv_r, res_inv_nxt;
  logic                           res_stat_r, res_stat_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [mi_pkg::INVERSE_W-1:0]   out_inv_r, out_inv_nxt;
  logic                           out_stat_r, out_stat_nxt;

  logic [W-1:0]                   m_in;
  mi_pkg::div_ctl_t               dctl;
  mi_pkg::div_sts_t               dsts;
  logic [DW-1:0]                  div_dividend;
  logic [W-1:0]                   div_divisor;
  logic [W-1:0]                   div_coef;
  logic [W-1:0]                   div_rem;
  logic [W-1:0]                   div_acc;

  assign m_in = W'(in_bus.modulus);

  mi_div_unit #(
    .W  (W),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .coef     (div_coef),
    .sts      (dsts),
    .rem      (div_rem),
    .acc      (div_acc)
  );

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    neg_nxt       = neg_r;
    res_inv_nxt   = res_inv_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r & ~out_bus.ready;
    out_inv_nxt   = out_inv_r;
    out_stat_nxt  = out_stat_r;
    dctl.start    = 1'b0;
    div_dividend  = DW'(r0_r);
    div_divisor   = r1_r;
    div_coef      = t1_r;
    case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          m_nxt = m_in;
          if (m_in < W'(2)) begin
            res_inv_nxt  = '0;
            res_stat_nxt = mi_pkg::STATUS_FAIL;
            state_nxt    = S_DONE;
          end else begin
            dctl.start   = 1'b1;
            div_dividend = DW'(in_bus.value);
            div_divisor  = m_in;
            div_coef     = '0;
            state_nxt    = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (dsts.done) begin
          r0_nxt    = m_r;
          r1_nxt    = div_rem;
          t0_nxt    = '0;
          t1_nxt    = W'(1);
          neg_nxt   = 1'b0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (r1_r > W'(1)) begin
          dctl.start = 1'b1;
          state_nxt  = S_DIV;
        end else if (r1_r == '0) begin
          res_inv_nxt  = '0;
          res_stat_nxt = mi_pkg::STATUS_FAIL;
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_FIN_RED;
        end
      end
      S_DIV: begin
        if (dsts.done) begin
          r0_nxt    = r1_r;
          r1_nxt    = div_rem;
          t0_nxt    = t1_r;
          t1_nxt    = div_acc + t0_r;
          neg_nxt   = ~neg_r;
          state_nxt = S_CHECK;
        end
      end
      S_FIN_RED: begin
        if (t1_r >= m_r) begin
          t1_nxt = t1_r - m_r;
        end
        state_nxt = S_FIN_NEG;
      end
      S_FIN_NEG: begin
        res_inv_nxt  = (neg_r && (t1_r != '0)) ? (m_r - t1_r) : t1_r;
        res_stat_nxt = mi_pkg::STATUS_OK;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_inv_nxt   = mi_pkg::INVERSE_W'(res_inv_r);
          out_stat_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    m_r        <= m_nxt;
    r0_r       <= r0_nxt;
    r1_r       <= r1_nxt;
    t0_r       <= t0_nxt;
    t1_r       <= t1_nxt;
    neg_r      <= neg_nxt;
    res_inv_r  <= res_inv_nxt;
    res_stat_r <= res_stat_nxt;
    out_inv_r  <= out_inv_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign in_bus.ready    = (state_r == S_IDLE);
  assign out_bus.valid   = out_valid_r;
  assign out_bus.inverse = out_inv_r;
  assign out_bus.status  = out_stat_r;

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.ready |-> !dsts.busy)
    else $error("divider busy while block accepts a beat");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && (out_bus.status == mi_pkg::STATUS_FAIL)) |-> (out_bus.inverse == '0))
    else $error("failed result carries a nonzero inverse");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    dsts.done |=> !dsts.done)
    else $error("divider done held for more than one cycle");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && dsts.done) |-> (div_rem < r1_r))
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

// ----- bench/tb_modular_inverse.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_inverse: self-checking bench for the modular inverse block
// Sends (value, modulus) beats with random gaps and random back-pressure on
// the result side. Every accepted beat is run through an extended Euclid
// predictor, and every result is checked field by field against the oldest
// prediction. The run covers degenerate moduli, edge values, key-like pairs
// and mixed random pairs.
// ----------------------------------------------------------------------------

module tb_modular_inverse;

  localparam int          MODULUS_BITS = 32;
  localparam logic [63:0] MOD_MASK     = (MODULUS_BITS >= 32) ? 64'hFFFF_FFFF :
                                         ((64'd1 << MODULUS_BITS) - 64'd1);
  localparam int          IDLE_LIMIT   = 20000;
  localparam int          DRAIN_CYCLES = 2000;

  typedef struct packed {
    logic [mi_pkg::INVERSE_W-1:0] inverse;
    logic                         status;
  } inv_result_t;

  logic clk;
  logic rst_n;

  mi_in_if  in_if ();
  mi_out_if out_if ();

  modular_inverse #(
    .MODULUS_BITS(MODULUS_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_if),
    .out_bus(out_if)
  );

  inv_result_t expected_inverses[$];
  int          mismatches  = 0;
  int          idle_cycles = 0;
  bit          in_burst    = 1'b0;
  bit          out_burst   = 1'b0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic inv_result_t predict_inverse(logic [mi_pkg::VALUE_W-1:0] v,
                                                  logic [mi_pkg::MOD_IN_W-1:0] m_in);
    logic [63:0] m, r0, r1, r2, q, t0, t1, t2;
    logic        neg;
    inv_result_t res;
    res.inverse = '0;
    res.status  = mi_pkg::STATUS_FAIL;
    m = {32'd0, m_in} & MOD_MASK;
    if (m < 64'd2) return res;
    r0  = m;
    r1  = {48'd0, v} % m;
    t0  = 64'd0;
    t1  = 64'd1;
    neg = 1'b0;
    while (r1 > 64'd1) begin
      q   = r0 / r1;
      r2  = r0 - q * r1;
      t2  = t0 + q * t1;
      r0  = r1;
      r1  = r2;
      t0  = t1;
      t1  = t2;
      neg = ~neg;
    end
    if (r1 == 64'd0) return res;
    t1 = t1 % m;
    if (neg && t1 != 64'd0) t1 = m - t1;
    res.inverse = t1[mi_pkg::INVERSE_W-1:0];
    res.status  = mi_pkg::STATUS_OK;
    return res;
  endfunction

  function automatic logic [mi_pkg::MOD_IN_W-1:0] draw_modulus();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(2, 300);
      1:       return $urandom_range(2, 65535);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pair(input logic [mi_pkg::VALUE_W-1:0] v,
                           input logic [mi_pkg::MOD_IN_W-1:0] m);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 15) == 0) in_burst = ~in_burst;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.value   = v;
    in_if.modulus = m;
    do @(posedge clk); while (!in_if.ready);
    expected_inverses.push_back(predict_inverse(v, m));
  endtask

  task automatic test_degenerate_moduli();
    send_pair(16'd0, 32'd0);
    send_pair(16'hFFFF, 32'd0);
    send_pair(16'd1, 32'd1);
    send_pair(16'hFFFF, 32'd1);
    send_pair(16'd1, 32'd2);
    send_pair(16'd0, 32'd2);
  endtask

  task automatic test_edge_values();
    send_pair(16'd0, 32'hFFFF_FFFF);
    send_pair(16'd1, 32'hFFFF_FFFF);
    send_pair(16'hFFFF, 32'hFFFF_FFFF);
    send_pair(16'd3, 32'hFFFF_FFFF);
    send_pair(16'd3, 32'h8000_0000);
    send_pair(16'hFFFF, 32'h0001_0000);
    send_pair(16'hFFFF, 32'd7);
    send_pair(16'd8, 32'd7);
    send_pair(16'd14, 32'd7);
    send_pair(16'd6, 32'd9);
    send_pair(16'd46368, 32'd75025);
    send_pair(16'd17, 32'hFFFF_FFFE);
    send_pair(16'd3, 32'd3120);
    send_pair(16'hAAAA, 32'h5555_5555);
    send_pair(16'h5555, 32'hAAAA_AAAB);
  endtask

  task automatic test_random_keys(input int count);
    logic [mi_pkg::VALUE_W-1:0]  v;
    logic [mi_pkg::MOD_IN_W-1:0] m;
    repeat (count) begin
      case ($urandom_range(0, 3))
        0:       v = 16'd3;
        1:       v = 16'd17;
        2:       v = 16'd257;
        default: v = 16'($urandom_range(0, 65535)) | 16'd1;
      endcase
      m = draw_modulus() & ~32'd1;
      if (m < 32'd2) m = 32'd2;
      send_pair(v, m);
    end
  endtask

  task automatic test_random_mixed(input int count);
    logic [mi_pkg::VALUE_W-1:0]  v;
    logic [mi_pkg::MOD_IN_W-1:0] m;
    int unsigned                 g;
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: begin
          v = 16'($urandom_range(0, 65535));
          m = $urandom;
        end
        1: begin
          v = 16'($urandom_range(0, 65535));
          m = draw_modulus();
        end
        2: begin
          // share a factor so no inverse exists
          g = $urandom_range(2, 255);
          v = 16'(g * $urandom_range(1, 255));
          m = g * $urandom_range(2, 32'hFFFF_FFFF / g);
        end
        default: begin
          v = 16'($urandom_range(2, 65535));
          m = $urandom_range(0, v);
        end
      endcase
      send_pair(v, m);
    end
  endtask

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          stall;
    inv_result_t want;
    out_if.ready = 1'b0;
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 15) == 0) out_burst = ~out_burst;
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (!out_if.valid);
      if (expected_inverses.size() == 0) begin
        $error("unexpected result beat: inverse %0h status %0b",
               out_if.inverse, out_if.status);
        mismatches++;
      end else begin
        want = expected_inverses.pop_front();
        if (out_if.inverse !== want.inverse) begin
          $error("inverse: expected %0h actual %0h", want.inverse, out_if.inverse);
          mismatches++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0b actual %0b", want.status, out_if.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.value   = '0;
    in_if.modulus = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_degenerate_moduli();
    test_edge_values();
    test_random_keys(150);
    test_random_mixed(150);

    @(negedge clk);
    in_if.valid = 1'b0;
    while (expected_inverses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mi_pkg.sv
rtl/core/mi_in_if.sv
rtl/core/mi_out_if.sv
rtl/core/mi_div_unit.sv
rtl/core/modular_inverse.sv
bench/tb_modular_inverse.sv
